// ===== rtl/core/dth_pkg.sv =====
// ----------------------------------------------------------------------------
// dth_pkg
// Shared types, codes and the heap key order for the deadline timer heap.
// ----------------------------------------------------------------------------
package dth_pkg;

	localparam int NUM_IDS = 64;
	localparam int MAX_RES = 64;

	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_ABANDON = 2'd1,
		OP_EXPIRE  = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ARMED     = 3'd0,
		ST_CLOSED    = 3'd1,
		ST_ID_BUSY   = 3'd2,
		ST_FULL      = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_CANCELLED = 3'd5,
		ST_ABANDONED = 3'd6,
		ST_NOTHING   = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         timer_id;
		logic signed [63:0] deadline;
		logic signed [63:0] now;
		logic [6:0]         budget;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         timer_id_res;
		logic               last_of_run;
		logic               has_due;
		logic [6:0]         pending_count;
		logic               next_valid;
		logic signed [63:0] head_deadline;
	} out_item_t;

	// classified command handed from the front to the back
	typedef struct packed {
		op_t                op;
		logic [5:0]         timer_id;
		logic signed [63:0] deadline;
		logic signed [63:0] now;
		logic [6:0]         budget;
	} cmd_t;

	typedef struct packed {
		logic signed [63:0] dl;
		logic [63:0]        seq;
		logic [5:0]         tid;
	} heap_entry_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_AB_SLOT,
		B_RM_RD,
		B_RM_GOT,
		B_SUP_RD,
		B_SUP_CMP,
		B_SDN_RD,
		B_SDN_CMP,
		B_POP_CHK,
		B_EM_RD,
		B_EM_OUT
	} back_state_t;

	function automatic logic key_before(heap_entry_t a, heap_entry_t b);
		if (a.dl != b.dl)
			return a.dl < b.dl;
		return a.seq < b.seq;
	endfunction

endpackage

// ===== rtl/core/deadline_timer_heap_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_heap_core
// Min-heap timer queue ordered by deadline then arm order, with abandon by
// id, budgeted expiry and cancel-all.
//
//   channel | direction | handshake         | beat
//   in      | input     | in_valid/ready    | in_item_t command
//   out     | output    | out_valid/ready   | out_item_t result
//   cfg     | input     | cfg_we            | accept_new bit
//
// Arm or removal: one registered memory read and compare per heap level;
// each result beat is read from the result memory before it is offered.
// One command is worked at a time; the two-entry input queue takes up to two
// beats while results stall. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module deadline_timer_heap_core #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  dth_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output dth_pkg::out_item_t out_item
);
	import dth_pkg::*;

	logic accept_new_q;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			accept_new_q <= 1'b1;
		else if (cfg_we)
			accept_new_q <= cfg_wdata;
	end

	dth_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	dth_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept_new (accept_new_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_cmd      (q_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// ===== rtl/core/dth_front.sv =====
// ----------------------------------------------------------------------------
// dth_front
// Accepts input beats, decodes the action, saturates the budget and queues
// the commands in a two-entry queue toward the heap engine.
// ----------------------------------------------------------------------------
module dth_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dth_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_ready,
	output dth_pkg::cmd_t     q_cmd
);
	import dth_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.op       = op_t'(in_item.action);
		cls.timer_id = in_item.timer_id;
		cls.deadline = in_item.deadline;
		cls.now      = in_item.now;
		cls.budget   = (in_item.budget > 7'(MAX_RES)) ? 7'(MAX_RES) : in_item.budget;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = buf_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/dth_back.sv =====
// ----------------------------------------------------------------------------
// dth_back
// Heap engine: sifts entries through the heap memory one level at a time (a
// read state, then a compare state), keeps the id-to-slot map, buffers the ids
// of one run and then emits the result beats with the after-item summary.
// ----------------------------------------------------------------------------
module dth_back #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept_new,
	input  logic               q_valid,
	output logic               q_ready,
	input  dth_pkg::cmd_t      q_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output dth_pkg::out_item_t out_item
);
	import dth_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = IW + 2;

	heap_entry_t heap_mem [CAPACITY];
	logic [IW-1:0] slot_mem [NUM_IDS];
	logic [5:0]    res_mem [MAX_RES];

	heap_entry_t rd_a_q, rd_b_q;
	logic [IW-1:0] slot_rd_q;
	logic [5:0]    res_rd_q;

	back_state_t state_q, state_d;
	op_t         op_q, op_d;
	logic [5:0]  id_q, id_d;
	logic signed [63:0] now_q, now_d;
	logic [6:0]  budget_q, budget_d;
	logic [IW-1:0] i_q, i_d;
	heap_entry_t key_q, key_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [63:0] seq_q, seq_d;
	logic [NUM_IDS-1:0] inheap_q, inheap_d;
	logic [6:0]  n_q, n_d;
	logic [6:0]  k_q, k_d;
	status_t     status_q, status_d;
	logic        due_q, due_d;
	logic        rmf_q, rmf_d;
	logic signed [63:0] top_q;

	logic          hw_en;
	logic [IW-1:0] hw_addr;
	heap_entry_t   hw_data;
	logic          sw_en;
	logic [5:0]    sw_addr;
	logic [IW-1:0] sw_data;
	logic          rw_en;
	logic [5:0]    rw_addr;
	logic [5:0]    rw_data;
	logic [IW-1:0] ra, rb;

	logic [CW-1:0] last;
	logic [IW-1:0] parent;
	logic [XW-1:0] lch, rch, cnt_x;
	logic          due_now;
	logic          use_r;
	heap_entry_t   best;
	logic [IW-1:0] best_idx;
	logic          is_pop;
	back_state_t   ret_state;

	assign last    = cnt_q - 1'b1;
	assign parent  = IW'((i_q - 1'b1) >> 1);
	assign lch     = XW'({i_q, 1'b1});
	assign rch     = lch + 1'b1;
	assign cnt_x   = XW'(cnt_q);
	assign due_now = (cnt_q != '0) && (top_q <= now_q);
	assign use_r   = (rch < cnt_x) && key_before(rd_b_q, rd_a_q);
	assign best    = use_r ? rd_b_q : rd_a_q;
	assign best_idx = use_r ? IW'(rch) : IW'(lch);
	assign is_pop  = (op_q == OP_EXPIRE) || (op_q == OP_CANCEL);
	assign ret_state = is_pop ? B_POP_CHK : B_EM_RD;

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		id_d     = id_q;
		now_d    = now_q;
		budget_d = budget_q;
		i_d      = i_q;
		key_d    = key_q;
		cnt_d    = cnt_q;
		seq_d    = seq_q;
		inheap_d = inheap_q;
		n_d      = n_q;
		k_d      = k_q;
		status_d = status_q;
		due_d    = due_q;
		rmf_d    = rmf_q;
		hw_en    = 1'b0;
		hw_addr  = i_q;
		hw_data  = key_q;
		sw_en    = 1'b0;
		sw_addr  = key_q.tid;
		sw_data  = i_q;
		rw_en    = 1'b0;
		rw_addr  = '0;
		rw_data  = id_q;
		ra       = i_q;
		rb       = IW'(last);
		q_ready  = 1'b0;
		out_valid = 1'b0;

		unique case (state_q)
			B_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					op_d     = q_cmd.op;
					id_d     = q_cmd.timer_id;
					now_d    = q_cmd.now;
					budget_d = q_cmd.budget;
					n_d      = 7'd0;
					k_d      = 7'd0;
					due_d    = 1'b0;
					rmf_d    = 1'b0;
					rw_data  = q_cmd.timer_id;
					unique case (q_cmd.op)
						OP_ARM: begin
							rw_en = 1'b1;
							n_d   = 7'd1;
							if (!accept_new) begin
								status_d = ST_CLOSED;
								state_d  = B_EM_RD;
							end else if (inheap_q[q_cmd.timer_id]) begin
								status_d = ST_ID_BUSY;
								state_d  = B_EM_RD;
							end else if (32'(cnt_q) >= CAPACITY) begin
								status_d = ST_FULL;
								state_d  = B_EM_RD;
							end else begin
								status_d = ST_ARMED;
								key_d    = '{dl: q_cmd.deadline, seq: seq_q,
								             tid: q_cmd.timer_id};
								i_d      = IW'(cnt_q);
								cnt_d    = cnt_q + 1'b1;
								seq_d    = seq_q + 64'd1;
								inheap_d[q_cmd.timer_id] = 1'b1;
								state_d  = B_SUP_RD;
							end
						end
						OP_ABANDON: begin
							rw_en = 1'b1;
							n_d   = 7'd1;
							if (inheap_q[q_cmd.timer_id]) begin
								status_d = ST_ABANDONED;
								state_d  = B_AB_SLOT;
							end else begin
								status_d = ST_NOTHING;
								state_d  = B_EM_RD;
							end
						end
						default: state_d = B_POP_CHK;
					endcase
				end
			end
			B_AB_SLOT: begin
				i_d     = slot_rd_q;
				state_d = B_RM_RD;
			end
			B_RM_RD: begin
				ra      = i_q;
				rb      = IW'(last);
				state_d = B_RM_GOT;
			end
			B_RM_GOT: begin
				inheap_d[rd_a_q.tid] = 1'b0;
				cnt_d = last;
				if (is_pop) begin
					rw_en   = 1'b1;
					rw_addr = n_q[5:0];
					rw_data = rd_a_q.tid;
					n_d     = n_q + 7'd1;
				end
				if (XW'(i_q) < XW'(last)) begin
					key_d = rd_b_q;
					if (i_q != '0) begin
						rmf_d   = 1'b1;
						state_d = B_SUP_RD;
					end else begin
						state_d = B_SDN_RD;
					end
				end else begin
					state_d = ret_state;
				end
			end
			B_SUP_RD: begin
				if (i_q == '0) begin
					hw_en   = 1'b1;
					sw_en   = 1'b1;
					state_d = ret_state;
				end else begin
					ra      = parent;
					state_d = B_SUP_CMP;
				end
			end
			B_SUP_CMP: begin
				rmf_d = 1'b0;
				if (key_before(key_q, rd_a_q)) begin
					// move the parent down into the hole
					hw_en   = 1'b1;
					hw_data = rd_a_q;
					sw_en   = 1'b1;
					sw_addr = rd_a_q.tid;
					i_d     = parent;
					state_d = B_SUP_RD;
				end else if (rmf_q) begin
					state_d = B_SDN_RD;
				end else begin
					hw_en   = 1'b1;
					sw_en   = 1'b1;
					state_d = ret_state;
				end
			end
			B_SDN_RD: begin
				if (lch >= cnt_x) begin
					hw_en   = 1'b1;
					sw_en   = 1'b1;
					state_d = ret_state;
				end else begin
					ra      = IW'(lch);
					rb      = IW'(rch);
					state_d = B_SDN_CMP;
				end
			end
			B_SDN_CMP: begin
				if (key_before(best, key_q)) begin
					hw_en   = 1'b1;
					hw_data = best;
					sw_en   = 1'b1;
					sw_addr = best.tid;
					i_d     = best_idx;
					state_d = B_SDN_RD;
				end else begin
					hw_en   = 1'b1;
					sw_en   = 1'b1;
					state_d = ret_state;
				end
			end
			B_POP_CHK: begin
				if ((op_q == OP_EXPIRE) ? ((n_q < budget_q) && due_now)
				                        : ((cnt_q != '0) && (n_q < 7'(MAX_RES)))) begin
					i_d     = '0;
					state_d = B_RM_RD;
				end else begin
					due_d = (op_q == OP_EXPIRE) && due_now;
					if (n_q == 7'd0) begin
						rw_en    = 1'b1;
						rw_addr  = '0;
						rw_data  = '0;
						n_d      = 7'd1;
						status_d = ST_NOTHING;
					end else begin
						status_d = (op_q == OP_EXPIRE) ? ST_EXPIRED : ST_CANCELLED;
					end
					state_d = B_EM_RD;
				end
			end
			B_EM_RD: begin
				state_d = B_EM_OUT;
			end
			B_EM_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (k_q + 7'd1 == n_q) begin
						state_d = B_IDLE;
					end else begin
						k_d     = k_q + 7'd1;
						state_d = B_EM_RD;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		out_item.status        = status_q;
		out_item.timer_id_res  = res_rd_q;
		out_item.last_of_run   = (k_q + 7'd1 == n_q);
		out_item.has_due       = due_q;
		out_item.pending_count = (32'(cnt_q) > 127) ? 7'd127 : 7'(cnt_q);
		out_item.next_valid    = (cnt_q != '0);
		out_item.head_deadline = (cnt_q != '0) ? top_q : 64'sd0;
	end

	// memories: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (hw_en)
			heap_mem[hw_addr] <= hw_data;
		rd_a_q <= heap_mem[ra];
		rd_b_q <= heap_mem[rb];
		if (sw_en)
			slot_mem[sw_addr] <= sw_data;
		slot_rd_q <= slot_mem[q_cmd.timer_id];
		if (rw_en)
			res_mem[rw_addr] <= rw_data;
		res_rd_q <= res_mem[k_q[5:0]];
		// shadow the root deadline
		if (hw_en && hw_addr == '0)
			top_q <= hw_data.dl;
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		id_q     <= id_d;
		now_q    <= now_d;
		budget_q <= budget_d;
		i_q      <= i_d;
		key_q    <= key_d;
		status_q <= status_d;
		due_q    <= due_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			seq_q    <= '0;
			inheap_q <= '0;
			n_q      <= '0;
			k_q      <= '0;
			rmf_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			seq_q    <= seq_d;
			inheap_q <= inheap_d;
			n_q      <= n_d;
			k_q      <= k_d;
			rmf_q    <= rmf_d;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deadline timer heap: random and directed
// commands feed a timer-set predictor and every result beat is compared.
// ----------------------------------------------------------------------------
module testbench;
	import dth_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	deadline_timer_heap_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	in_item_t  cmd_q[$];
	out_item_t beat_q[$];
	int        tx_idle;
	int        rx_idle;
	int        hold_ask;
	int        hold_seen;
	int        hold_left;
	int        errors;

	// timer set kept by id; the earliest key is found by a scan
	logic               armed[NUM_IDS];
	logic signed [63:0] armed_dl[NUM_IDS];
	logic [63:0]        armed_seq[NUM_IDS];
	int                 armed_cnt;
	logic [63:0]        seq_next;
	logic               open_for_arm;

	function automatic int earliest_timer();
		int best;
		best = -1;
		for (int i = 0; i < NUM_IDS; i++) begin
			if (armed[i] && (best < 0 || armed_dl[i] < armed_dl[best] ||
				(armed_dl[i] == armed_dl[best] && armed_seq[i] < armed_seq[best])))
				best = i;
		end
		return best;
	endfunction

	function automatic logic timer_due(logic signed [63:0] now);
		return armed_cnt != 0 && armed_dl[earliest_timer()] <= now;
	endfunction

	function automatic void predict_beats(in_item_t it);
		status_t    st_q[$];
		logic [5:0] id_q[$];
		int         lim;
		int         m;
		logic       due;
		out_item_t  e;
		due = 1'b0;
		lim = it.budget > MAX_RES ? MAX_RES : it.budget;
		case (op_t'(it.action))
			OP_ARM: begin
				id_q.insert(id_q.size(), it.timer_id);
				if (!open_for_arm)
					st_q.insert(st_q.size(), ST_CLOSED);
				else if (armed[it.timer_id])
					st_q.insert(st_q.size(), ST_ID_BUSY);
				else if (armed_cnt >= 64)
					st_q.insert(st_q.size(), ST_FULL);
				else begin
					armed[it.timer_id] = 1'b1;
					armed_dl[it.timer_id] = it.deadline;
					armed_seq[it.timer_id] = seq_next;
					seq_next++;
					armed_cnt++;
					st_q.insert(st_q.size(), ST_ARMED);
				end
			end
			OP_ABANDON: begin
				id_q.insert(id_q.size(), it.timer_id);
				if (armed[it.timer_id]) begin
					armed[it.timer_id] = 1'b0;
					armed_cnt--;
					st_q.insert(st_q.size(), ST_ABANDONED);
				end else
					st_q.insert(st_q.size(), ST_NOTHING);
			end
			OP_EXPIRE: begin
				while (st_q.size() < lim && timer_due(it.now)) begin
					m = earliest_timer();
					armed[m] = 1'b0;
					armed_cnt--;
					st_q.insert(st_q.size(), ST_EXPIRED);
					id_q.insert(id_q.size(), m[5:0]);
				end
				due = timer_due(it.now);
			end
			default: begin
				while (st_q.size() < MAX_RES && armed_cnt != 0) begin
					m = earliest_timer();
					armed[m] = 1'b0;
					armed_cnt--;
					st_q.insert(st_q.size(), ST_CANCELLED);
					id_q.insert(id_q.size(), m[5:0]);
				end
			end
		endcase
		if (st_q.size() == 0) begin
			st_q.insert(st_q.size(), ST_NOTHING);
			id_q.insert(id_q.size(), 6'd0);
		end
		for (int k = 0; k < st_q.size(); k++) begin
			e.status        = st_q[k];
			e.timer_id_res  = id_q[k];
			e.last_of_run   = (k == st_q.size() - 1);
			e.has_due       = due;
			e.pending_count = armed_cnt[6:0];
			e.next_valid    = armed_cnt != 0;
			e.head_deadline = armed_cnt != 0 ? armed_dl[earliest_timer()] : '0;
			beat_q.insert(beat_q.size(), e);
		end
	endfunction

	function automatic void push_cmd(op_t op, int id, logic signed [63:0] dl,
			logic signed [63:0] now, int budget);
		in_item_t it;
		it.action   = op;
		it.timer_id = id[5:0];
		it.deadline = dl;
		it.now      = now;
		it.budget   = budget[6:0];
		cmd_q.insert(cmd_q.size(), it);
	endfunction

	function automatic logic signed [63:0] pick_time();
		case ($urandom_range(9))
			0: return 64'sh8000_0000_0000_0000;
			1: return 64'sh7fff_ffff_ffff_ffff;
			2, 3, 4, 5: return $signed(64'($urandom_range(2000))) - 64'sd1000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void push_random();
		int pick;
		int id;
		int bud;
		pick = $urandom_range(99);
		id   = $urandom_range(9) < 6 ? $urandom_range(15) : $urandom_range(63);
		bud  = $urandom_range(9) < 8 ? $urandom_range(8) : $urandom_range(127);
		if (pick < 47)
			push_cmd(OP_ARM, id, pick_time(), pick_time(), $urandom_range(127));
		else if (pick < 67)
			push_cmd(OP_ABANDON, id, pick_time(), pick_time(), $urandom_range(127));
		else if (pick < 97)
			push_cmd(OP_EXPIRE, $urandom_range(63), pick_time(), pick_time(), bud);
		else
			push_cmd(OP_CANCEL, $urandom_range(63), pick_time(), pick_time(), bud);
	endfunction

	task automatic drain();
		wait (cmd_q.size() == 0 && !in_valid && beat_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_accept(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		open_for_arm = v;
	endtask

	task automatic report(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// driver: present the head of the command queue, drop it once taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin : drv
			logic take;
			take = in_valid && in_ready;
			if (take) begin
				predict_beats(in_item);
				void'(cmd_q.pop_front());
			end
			if (!in_valid || take) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
					in_valid <= 1'b1;
					in_item  <= cmd_q[0];
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= $urandom_range(99) >= rx_idle;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin : mon
			out_item_t e;
			if (beat_q.size() == 0) begin
				errors++;
				$display("%0t unexpected beat %p", $time, out_item);
			end else begin
				e = beat_q.pop_front();
				report("status", e.status, out_item.status);
				report("timer_id_res", e.timer_id_res, out_item.timer_id_res);
				report("last_of_run", e.last_of_run, out_item.last_of_run);
				report("has_due", e.has_due, out_item.has_due);
				report("pending_count", e.pending_count, out_item.pending_count);
				report("next_valid", e.next_valid, out_item.next_valid);
				report("head_deadline", e.head_deadline, out_item.head_deadline);
			end
		end
	end

	initial begin
		errors       = 0;
		hold_ask     = 0;
		armed_cnt    = 0;
		seq_next     = '0;
		open_for_arm = 1'b1;
		for (int i = 0; i < NUM_IDS; i++)
			armed[i] = 1'b0;
		tx_idle   = 38;
		rx_idle   = 84;
		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_accept(1'b1);
		// ties on deadline, extremes, busy id, misses, empty-heap cases
		push_cmd(OP_ARM, 5, 0, 0, 0);
		push_cmd(OP_ARM, 9, 0, 0, 0);
		push_cmd(OP_ARM, 0, 64'sh8000_0000_0000_0000, 0, 0);
		push_cmd(OP_ARM, 63, 64'sh7fff_ffff_ffff_ffff, 0, 0);
		push_cmd(OP_ARM, 5, 12, 0, 0);
		push_cmd(OP_ABANDON, 40, 0, 0, 0);
		push_cmd(OP_ABANDON, 9, 0, 0, 0);
		push_cmd(OP_EXPIRE, 0, 0, 64'sh7fff_ffff_ffff_ffff, 0);
		push_cmd(OP_EXPIRE, 0, 0, -64'sd1, 64);
		push_cmd(OP_EXPIRE, 0, 0, 64'sh8000_0000_0000_0000, 1);
		push_cmd(OP_EXPIRE, 0, 0, 0, 64);
		push_cmd(OP_EXPIRE, 0, 0, 64'sh7fff_ffff_ffff_ffff, 127);
		push_cmd(OP_CANCEL, 0, 0, 0, 0);
		push_cmd(OP_EXPIRE, 0, 0, 0, 5);
		push_cmd(OP_ARM, 1, 7, 0, 0);
		push_cmd(OP_ARM, 2, 7, 0, 0);
		push_cmd(OP_ARM, 3, -64'sd7, 0, 0);
		push_cmd(OP_EXPIRE, 0, 0, 7, 65);
		push_cmd(OP_ARM, 4, 64'sh7fff_ffff_ffff_ffff, 0, 0);
		push_cmd(OP_CANCEL, 0, 0, 0, 127);
		push_cmd(OP_ABANDON, 63, 0, 0, 0);
		drain();

		// long receiver hold while commands keep coming
		hold_ask++;
		for (int i = 0; i < 110; i++)
			push_random();
		drain();

		write_accept(1'b0);
		for (int i = 0; i < 20; i++)
			push_random();
		drain();
		write_accept(1'b1);

		tx_idle = 84;
		rx_idle = 38;
		for (int i = 0; i < 64; i++)
			push_cmd(OP_ARM, i, pick_time(), 0, 0);
		push_cmd(OP_ARM, 17, 0, 0, 0);
		push_cmd(OP_EXPIRE, 0, 0, 64'sh7fff_ffff_ffff_ffff, 127);
		for (int i = 0; i < 40; i++)
			push_random();
		drain();

		tx_idle = 0;
		rx_idle = 0;
		for (int i = 0; i < 64; i++)
			push_cmd(OP_ARM, 63 - i, pick_time(), 0, 0);
		push_cmd(OP_CANCEL, 0, 0, 0, 0);
		for (int i = 0; i < 40; i++)
			push_random();
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dth_pkg.sv
rtl/core/dth_front.sv
rtl/core/dth_back.sv
rtl/core/deadline_timer_heap_core.sv
tb/sv/testbench.sv
